>>> design/bph_pkg.sv
// bph_pkg: shared types, constants and codes of the board position hash block
// used by bph_ctrl, bph_datapath and board_position_hash_top

package bph_pkg;

    localparam int unsigned HASH_W     = 64;
    localparam int unsigned CALL_W     = 10;
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned IN_USER_W  = 1;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 64;

    localparam int unsigned PIECE_CODES = 12;

    localparam logic [CALL_W-1:0] CASTLE_BASE = 10'd769;
    localparam logic [CALL_W-1:0] EP_BASE     = 10'd785;
    localparam logic [CALL_W-1:0] SIDE_CALL   = 10'd793;

    localparam logic [HASH_W-1:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
    localparam logic [HASH_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [HASH_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

    localparam logic [HASH_W-1:0] SEED_RESET = 64'd42;
    localparam logic [2:0]        PAWN_RESET = 3'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_SEED  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAWN_KIND = 1'b1;

    localparam logic REQ_ADD    = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    typedef enum logic [2:0] {
        OP_IDLE = 3'd0,
        OP_LOAD = 3'd1,
        OP_PREP = 3'd2,
        OP_MUL  = 3'd3,
        OP_FOLD = 3'd4,
        OP_EMIT = 3'd5
    } t_dp_op;

    typedef enum logic [1:0] {
        KEY_PIECE  = 2'd0,
        KEY_SIDE   = 2'd1,
        KEY_CASTLE = 2'd2,
        KEY_EP     = 2'd3
    } t_key_sel;

    typedef enum logic [1:0] {
        ROUND_SEED = 2'd0,
        ROUND_MIX1 = 2'd1,
        ROUND_MIX2 = 2'd2
    } t_round;

    typedef enum logic [1:0] {
        PART_LL = 2'd0,
        PART_LH = 2'd1,
        PART_HL = 2'd2
    } t_part;

    typedef struct packed {
        t_dp_op   op;
        t_key_sel key;
        t_round   round;
        t_part    part;
    } t_dp_cmd;

    typedef struct packed {
        logic is_finish;
        logic side_black;
        logic capture;
        logic out_free;
    } t_dp_stat;

    function automatic logic [HASH_W-1:0] round_const(input t_round rnd);
        logic [HASH_W-1:0] c;
        unique case (rnd)
            ROUND_SEED: c = GOLDEN_STEP;
            ROUND_MIX1: c = MIX_MUL_A;
            ROUND_MIX2: c = MIX_MUL_B;
            default:    c = GOLDEN_STEP;
        endcase
        return c;
    endfunction

endpackage

>>> design/bph_ctrl.sv
// bph_ctrl: sequencer of the board position hash block
// steps each key through seed, two mix rounds and fold; uses bph_pkg

module bph_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bph_pkg::t_dp_stat i_stat,
    output bph_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SELECT = 6'b000010,
        ST_PREP   = 6'b000100,
        ST_MUL    = 6'b001000,
        ST_FOLD   = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    bph_pkg::t_key_sel r_key, n_key;
    bph_pkg::t_round   r_round, n_round;
    bph_pkg::t_part    r_part, n_part;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_key   <= bph_pkg::KEY_PIECE;
            r_round <= bph_pkg::ROUND_SEED;
            r_part  <= bph_pkg::PART_LL;
        end else begin
            r_state <= n_state;
            r_key   <= n_key;
            r_round <= n_round;
            r_part  <= n_part;
        end
    end

    always_comb begin
        n_state = r_state;
        n_key   = r_key;
        n_round = r_round;
        n_part  = r_part;
        o_cmd.op    = bph_pkg::OP_IDLE;
        o_cmd.key   = r_key;
        o_cmd.round = r_round;
        o_cmd.part  = r_part;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = bph_pkg::OP_LOAD;
                    n_state  = ST_SELECT;
                end
            end
            ST_SELECT: begin
                if (!i_stat.is_finish) begin
                    n_key = bph_pkg::KEY_PIECE;
                end else if (i_stat.side_black) begin
                    n_key = bph_pkg::KEY_SIDE;
                end else begin
                    n_key = bph_pkg::KEY_CASTLE;
                end
                n_round = bph_pkg::ROUND_SEED;
                n_state = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.op = bph_pkg::OP_PREP;
                n_part   = bph_pkg::PART_LL;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.op = bph_pkg::OP_MUL;
                unique case (r_part)
                    bph_pkg::PART_LL: n_part = bph_pkg::PART_LH;
                    bph_pkg::PART_LH: n_part = bph_pkg::PART_HL;
                    default: begin
                        n_part = bph_pkg::PART_LL;
                        unique case (r_round)
                            bph_pkg::ROUND_SEED: begin
                                n_round = bph_pkg::ROUND_MIX1;
                                n_state = ST_PREP;
                            end
                            bph_pkg::ROUND_MIX1: begin
                                n_round = bph_pkg::ROUND_MIX2;
                                n_state = ST_PREP;
                            end
                            default: begin
                                n_state = ST_FOLD;
                            end
                        endcase
                    end
                endcase
            end
            ST_FOLD: begin
                o_cmd.op = bph_pkg::OP_FOLD;
                n_round  = bph_pkg::ROUND_SEED;
                unique case (r_key)
                    bph_pkg::KEY_PIECE: n_state = ST_IDLE;
                    bph_pkg::KEY_SIDE: begin
                        n_key   = bph_pkg::KEY_CASTLE;
                        n_state = ST_PREP;
                    end
                    bph_pkg::KEY_CASTLE: begin
                        if (i_stat.capture) begin
                            n_key   = bph_pkg::KEY_EP;
                            n_state = ST_PREP;
                        end else begin
                            n_state = ST_EMIT;
                        end
                    end
                    default: n_state = ST_EMIT;
                endcase
            end
            ST_EMIT: begin
                o_cmd.op = bph_pkg::OP_EMIT;
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == ST_IDLE);

    a_accept_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SELECT))
        else $error("accepted item did not move to key select");

    a_fold_after_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOLD) |->
            ($past(r_state) == ST_MUL && $past(r_round) == bph_pkg::ROUND_MIX2
             && $past(r_part) == bph_pkg::PART_HL))
        else $error("fold reached before the last multiply finished");

    a_emit_only_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> i_stat.is_finish)
        else $error("emit reached for an add item");

endmodule

>>> design/bph_datapath.sv
// bph_datapath: key mixer with one shared 32x32 multiplier, hash and pawn rows
// holds config registers and the output register; uses bph_pkg

module bph_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bph_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bph_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [bph_pkg::IN_DATA_W-1:0]       i_in_data,
    input  logic [bph_pkg::IN_USER_W-1:0]       i_in_user,
    input  bph_pkg::t_dp_cmd                    i_cmd,
    output bph_pkg::t_dp_stat                   o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [bph_pkg::HASH_W-1:0]          o_out_data
);

    localparam int unsigned HW = bph_pkg::HASH_W;
    localparam int unsigned QW = bph_pkg::HALF_W;
    localparam int unsigned CW = bph_pkg::CALL_W;

    logic [HW-1:0] r_seed;
    logic [2:0]    r_pawn_kind;

    logic          r_req;
    logic [5:0]    r_square;
    logic [2:0]    r_kind;
    logic          r_owner;
    logic          r_side;
    logic [3:0]    r_rights;
    logic          r_ep_valid;
    logic [2:0]    r_ep_col;

    logic [HW-1:0] r_a;
    logic [HW-1:0] r_acc;
    logic [HW-1:0] r_hash;
    logic [7:0]    r_white;
    logic [7:0]    r_black;
    logic          r_out_valid;
    logic [HW-1:0] r_out_data;

    logic [5:0]    in_square;
    logic [2:0]    in_kind;
    logic          in_owner;
    logic          in_add;

    logic [CW-1:0] call_n;
    logic [HW-1:0] seed_sum;
    logic [HW-1:0] round_c;
    logic [QW-1:0] mul_a;
    logic [QW-1:0] mul_b;
    logic [HW-1:0] mul_p;
    logic [7:0]    pawns;
    logic          left_hit;
    logic          right_hit;
    logic          out_free;

    assign in_square = i_in_data[5:0];
    assign in_kind   = i_in_data[8:6];
    assign in_owner  = i_in_data[9];
    assign in_add    = (i_in_user[0] == bph_pkg::REQ_ADD);

    always_comb begin
        unique case (i_cmd.key)
            bph_pkg::KEY_PIECE:
                call_n = CW'(r_square) * CW'(bph_pkg::PIECE_CODES)
                         + CW'({r_kind, 1'b0}) + CW'(r_owner) + CW'(1);
            bph_pkg::KEY_SIDE:   call_n = bph_pkg::SIDE_CALL;
            bph_pkg::KEY_CASTLE: call_n = bph_pkg::CASTLE_BASE + CW'(r_rights);
            default:             call_n = bph_pkg::EP_BASE + CW'(r_ep_col);
        endcase
    end

    assign seed_sum = r_seed + r_acc;
    assign round_c  = bph_pkg::round_const(i_cmd.round);
    assign mul_a    = (i_cmd.part == bph_pkg::PART_HL) ? r_a[HW-1:QW] : r_a[QW-1:0];
    assign mul_b    = (i_cmd.part == bph_pkg::PART_LH) ? round_c[HW-1:QW] : round_c[QW-1:0];
    assign mul_p    = {{QW{1'b0}}, mul_a} * {{QW{1'b0}}, mul_b};

    assign pawns     = r_side ? r_black : r_white;
    assign left_hit  = (r_ep_col != 3'd0) && pawns[r_ep_col - 3'd1];
    assign right_hit = (r_ep_col != 3'd7) && pawns[r_ep_col + 3'd1];
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= bph_pkg::SEED_RESET;
            r_pawn_kind <= bph_pkg::PAWN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bph_pkg::CFG_KEY_SEED:  r_seed      <= i_cfg_data;
                bph_pkg::CFG_PAWN_KIND: r_pawn_kind <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // item fields, key arithmetic and output data
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bph_pkg::OP_LOAD) begin
            r_req      <= i_in_user[0];
            r_square   <= in_square;
            r_kind     <= in_kind;
            r_owner    <= in_owner;
            r_side     <= i_in_data[10];
            r_rights   <= i_in_data[14:11];
            r_ep_valid <= i_in_data[15];
            r_ep_col   <= i_in_data[18:16];
        end
        if (i_cmd.op == bph_pkg::OP_PREP) begin
            unique case (i_cmd.round)
                bph_pkg::ROUND_SEED: r_a <= HW'(call_n);
                bph_pkg::ROUND_MIX1: r_a <= seed_sum ^ (seed_sum >> 30);
                default:             r_a <= r_acc ^ (r_acc >> 27);
            endcase
        end
        if (i_cmd.op == bph_pkg::OP_MUL) begin
            if (i_cmd.part == bph_pkg::PART_LL) begin
                r_acc <= mul_p;
            end else begin
                r_acc[HW-1:QW] <= r_acc[HW-1:QW] + mul_p[QW-1:0];
            end
        end
        if (i_cmd.op == bph_pkg::OP_EMIT && out_free) begin
            r_out_data <= r_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_white     <= '0;
            r_black     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == bph_pkg::OP_LOAD && in_add && in_kind == r_pawn_kind) begin
                if (!in_owner && in_square[5:3] == 3'd3) begin
                    r_white[in_square[2:0]] <= 1'b1;
                end else if (in_owner && in_square[5:3] == 3'd4) begin
                    r_black[in_square[2:0]] <= 1'b1;
                end
            end
            if (i_cmd.op == bph_pkg::OP_FOLD) begin
                r_hash <= r_hash ^ r_acc ^ (r_acc >> 31);
            end
            if (i_cmd.op == bph_pkg::OP_EMIT && out_free) begin
                r_hash      <= '0;
                r_white     <= '0;
                r_black     <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.is_finish  = (r_req == bph_pkg::REQ_FINISH);
    assign o_stat.side_black = r_side;
    assign o_stat.capture    = r_ep_valid && (left_hit || right_hit);
    assign o_stat.out_free   = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.op == bph_pkg::OP_EMIT))
        else $error("result raised without an emit");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == bph_pkg::OP_EMIT && out_free) |=>
            (r_hash == '0 && r_white == '0 && r_black == '0))
        else $error("position state not cleared after emit");

endmodule

>>> design/board_position_hash_top.sv
// board_position_hash_top: an add item hashes one piece key; ready returns once it is folded
// finish item: hashes k = 1..3 keys (side, castling, en passant); ready returns and the
// hash goes valid in the same cycle; emit waits while the last hash is not accepted
// each key takes three 64-bit multiplies on one shared 32x32 multiplier, each built from
// partial products LL, LH, HL after a prep step, then a fold; one item is worked on at a time
// synchronous active-low reset clears hash, pawn rows and output valid,
// sets key seed to 42 and pawn kind to 0; no clearing pass

module board_position_hash_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bph_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bph_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // square[5:0], piece_kind[8:6], piece_owner[9], side_to_move[10],
    // castling_rights[14:11], ep_valid[15], ep_column[18:16], zero fill
    input  logic [bph_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // req_type[0]
    input  logic [bph_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // position_hash[63:0]
    output logic [bph_pkg::HASH_W-1:0]         m_axis_tdata
);

    bph_pkg::t_dp_cmd  cmd;
    bph_pkg::t_dp_stat stat;

    bph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bph_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

>>> dv/board_position_hash_top_tb.sv
// board_position_hash_top_tb: self-checking testbench for the board position hash block
// drives square and finish items on the input stream, predicts each position hash,
// checks the output stream; depends on bph_pkg and board_position_hash_top

module board_position_hash_top_tb;

    localparam logic [63:0] KEY_STEP      = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] KEY_MUL_A     = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] KEY_MUL_B     = 64'h94d049bb133111eb;
    localparam logic [63:0] SQUARE_STRIDE = 64'd12;
    localparam logic [63:0] CALL_CASTLE0  = 64'd769;
    localparam logic [63:0] CALL_EP0      = 64'd785;
    localparam logic [63:0] CALL_SIDE     = 64'd793;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          DRAIN_LIMIT   = 4000;
    localparam int          MAX_REPORTS   = 10;

    typedef struct packed {
        logic       req;
        logic [5:0] square;
        logic [2:0] kind;
        logic       owner;
        logic       side;
        logic [3:0] rights;
        logic       ep_valid;
        logic [2:0] ep_col;
    } t_board_item;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [bph_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [bph_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    // square[5:0], piece_kind[8:6], piece_owner[9], side_to_move[10],
    // castling_rights[14:11], ep_valid[15], ep_column[18:16], zero fill
    logic [bph_pkg::IN_DATA_W-1:0]   s_axis_tdata;
    // req_type[0]
    logic [bph_pkg::IN_USER_W-1:0]   s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    // position_hash[63:0]
    logic [bph_pkg::HASH_W-1:0]      m_axis_tdata;

    logic [63:0] key_seed_cfg;
    logic [2:0]  pawn_kind_cfg;
    logic [63:0] acc_hash;
    logic [7:0]  white_row3;
    logic [7:0]  black_row4;
    logic [63:0] pending_hashes[$];
    logic [63:0] want_hash;
    int          n_failures;
    bit          src_idle_allowed;
    bit          src_idle_on;
    bit          snk_idle_on;

    board_position_hash_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("** board_position_hash_top: FAILED **");
        $finish;
    end

    function automatic logic [63:0] zobrist_key(input logic [63:0] seed,
                                                input logic [63:0] call_no);
        logic [63:0] z;
        z = seed + call_no * KEY_STEP;
        z = (z ^ (z >> 30)) * KEY_MUL_A;
        z = (z ^ (z >> 27)) * KEY_MUL_B;
        return z ^ (z >> 31);
    endfunction

    function automatic void note_failure(input string msg);
        n_failures++;
        if (n_failures <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void predict_position_hash(input t_board_item it);
        logic [63:0] h;
        logic [7:0]  pawns;
        if (it.req == bph_pkg::REQ_ADD) begin
            acc_hash ^= zobrist_key(key_seed_cfg,
                                    SQUARE_STRIDE * it.square + 64'd2 * it.kind
                                    + it.owner + 64'd1);
            if (it.kind == pawn_kind_cfg) begin
                if (!it.owner && it.square[5:3] == 3'd3) begin
                    white_row3[it.square[2:0]] = 1'b1;
                end else if (it.owner && it.square[5:3] == 3'd4) begin
                    black_row4[it.square[2:0]] = 1'b1;
                end
            end
        end else begin
            h = acc_hash;
            pawns = it.side ? black_row4 : white_row3;
            if (it.side) begin
                h ^= zobrist_key(key_seed_cfg, CALL_SIDE);
            end
            h ^= zobrist_key(key_seed_cfg, CALL_CASTLE0 + it.rights);
            if (it.ep_valid && ((it.ep_col != 3'd0 && pawns[it.ep_col - 3'd1])
                                || (it.ep_col != 3'd7 && pawns[it.ep_col + 3'd1]))) begin
                h ^= zobrist_key(key_seed_cfg, CALL_EP0 + it.ep_col);
            end
            pending_hashes.push_back(h);
            acc_hash = '0;
            white_row3 = '0;
            black_row4 = '0;
        end
    endfunction

    function automatic t_board_item random_item();
        t_board_item it;
        logic [31:0] raw;
        raw = $urandom;
        it = raw[$bits(t_board_item)-1:0];
        return it;
    endfunction

    task automatic send_item(input t_board_item it);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 19) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.req;
        s_axis_tdata  <= {5'b0, it.ep_col, it.ep_valid, it.rights, it.side,
                          it.owner, it.kind, it.square};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        predict_position_hash(it);
    endtask

    task automatic send_add(input logic [5:0] square, input logic [2:0] kind,
                            input logic owner);
        t_board_item it;
        it = random_item();
        it.req = bph_pkg::REQ_ADD;
        it.square = square;
        it.kind = kind;
        it.owner = owner;
        send_item(it);
    endtask

    task automatic send_finish(input logic side, input logic [3:0] rights,
                               input logic ep_valid, input logic [2:0] ep_col);
        t_board_item it;
        it = random_item();
        it.req = bph_pkg::REQ_FINISH;
        it.side = side;
        it.rights = rights;
        it.ep_valid = ep_valid;
        it.ep_col = ep_col;
        send_item(it);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_hashes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_hashes.size() != 0) begin
            note_failure($sformatf("%0d hashes never arrived", pending_hashes.size()));
            pending_hashes.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bph_pkg::CFG_IDX_W-1:0] idx,
                             input logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == bph_pkg::CFG_KEY_SEED) begin
            key_seed_cfg = value;
        end else begin
            pawn_kind_cfg = value[2:0];
        end
    endtask

    task automatic set_hash_config(input logic [63:0] seed, input logic [2:0] pawn);
        write_reg(bph_pkg::CFG_KEY_SEED, seed);
        write_reg(bph_pkg::CFG_PAWN_KIND, {61'b0, pawn});
    endtask

    // empty positions, field extremes, kinds beyond the pawn..king range, cancelling keys
    task automatic test_plain_positions();
        send_finish(1'b0, 4'd0, 1'b0, 3'd0);
        send_add(6'd0, 3'd0, 1'b0);
        send_add(6'd63, 3'd5, 1'b1);
        send_add(6'd5, 3'd6, 1'b1);
        send_add(6'd62, 3'd7, 1'b1);
        send_finish(1'b1, 4'd15, 1'b1, 3'd7);
        send_add(6'd10, 3'd3, 1'b0);
        send_add(6'd10, 3'd3, 1'b0);
        send_finish(1'b0, 4'd9, 1'b0, 3'd5);
    endtask

    // captures on both sides, edge columns, repeated pawn, ep flag clear, wrong side
    task automatic test_en_passant();
        send_add(6'd24, pawn_kind_cfg, 1'b0);
        send_finish(1'b0, 4'd3, 1'b1, 3'd1);
        send_add(6'd39, pawn_kind_cfg, 1'b1);
        send_finish(1'b1, 4'd12, 1'b1, 3'd6);
        send_add(6'd25, pawn_kind_cfg, 1'b0);
        send_finish(1'b0, 4'd1, 1'b1, 3'd0);
        send_add(6'd38, pawn_kind_cfg, 1'b1);
        send_finish(1'b1, 4'd6, 1'b1, 3'd7);
        send_add(6'd28, pawn_kind_cfg, 1'b0);
        send_add(6'd28, pawn_kind_cfg, 1'b0);
        send_finish(1'b0, 4'd0, 1'b1, 3'd3);
        send_add(6'd29, pawn_kind_cfg, 1'b0);
        send_finish(1'b0, 4'd15, 1'b0, 3'd4);
        send_add(6'd30, pawn_kind_cfg, 1'b0);
        send_finish(1'b1, 4'd5, 1'b1, 3'd5);
    endtask

    // random positions, many with a pawn placed to allow an en passant capture
    task automatic test_random_positions(input int n_items);
        t_board_item it;
        int          sent;
        int          n_adds;
        int          c;
        logic        side;
        bit          ep_try;
        sent = 0;
        while (sent < n_items) begin
            src_idle_on = src_idle_allowed && ($urandom_range(0, 3) != 0);
            snk_idle_on = src_idle_allowed && ($urandom_range(0, 3) != 0);
            n_adds = $urandom_range(0, 12);
            side = 1'($urandom_range(0, 1));
            ep_try = 1'($urandom_range(0, 1));
            c = $urandom_range(0, 7);
            for (int i = 0; i < n_adds; i++) begin
                it = random_item();
                it.req = bph_pkg::REQ_ADD;
                if (i == 0 && ep_try) begin
                    it.square = {(side ? 3'd4 : 3'd3), 3'(c)};
                    it.kind = pawn_kind_cfg;
                    it.owner = side;
                end else if ($urandom_range(0, 9) != 0) begin
                    it.kind = 3'($urandom_range(0, 5));
                end
                send_item(it);
            end
            it = random_item();
            it.req = bph_pkg::REQ_FINISH;
            it.side = side;
            if (ep_try && $urandom_range(0, 7) != 0) begin
                it.ep_valid = 1'b1;
                if (c == 0) begin
                    it.ep_col = 3'd1;
                end else if (c == 7) begin
                    it.ep_col = 3'd6;
                end else begin
                    it.ep_col = $urandom_range(0, 1) ? 3'(c + 1) : 3'(c - 1);
                end
            end
            send_item(it);
            sent += n_adds + 1;
            if ($urandom_range(0, 15) == 0) begin
                wait_drained();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hashes.size() == 0) begin
                note_failure($sformatf("unexpected hash %h", m_axis_tdata));
            end else begin
                want_hash = pending_hashes.pop_front();
                if (m_axis_tdata !== want_hash) begin
                    note_failure($sformatf("position_hash expected %h actual %h",
                                           want_hash, m_axis_tdata));
                end
            end
        end
    end

    // result side: random stall before each hash when sink idling is on
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            stall = snk_idle_on ? $urandom_range(0, 19) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        key_seed_cfg  = 64'd42;
        pawn_kind_cfg = 3'd0;
        acc_hash      = '0;
        white_row3    = '0;
        black_row4    = '0;
        n_failures    = 0;
        src_idle_allowed = 1'b1;
        src_idle_on   = 1'b1;
        snk_idle_on   = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_hash_config(64'd42, 3'd0);
        test_plain_positions();
        test_en_passant();
        wait_drained();

        set_hash_config(64'd0, 3'd5);
        test_random_positions(120);
        wait_drained();

        src_idle_allowed = 1'b0;
        set_hash_config(64'hffff_ffff_ffff_ffff, 3'd3);
        test_random_positions(120);
        wait_drained();
        src_idle_allowed = 1'b1;

        set_hash_config({$urandom, $urandom}, 3'($urandom_range(0, 5)));
        test_random_positions(150);
        wait_drained();

        set_hash_config({$urandom, $urandom}, 3'd0);
        test_en_passant();
        test_random_positions(100);
        wait_drained();

        if (n_failures == 0) begin
            $display("** board_position_hash_top: PASSED **");
        end else begin
            $display("** board_position_hash_top: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
design/bph_pkg.sv
design/bph_ctrl.sv
design/bph_datapath.sv
design/board_position_hash_top.sv
dv/board_position_hash_top_tb.sv
